// File: src/gpc_pkg.sv
// Package: shared constants and types of the gamepad poll conditioner.
`default_nettype none
package gpc_pkg;
  localparam logic [15:0] BUTTON_USED_MASK = 16'hF3FF;
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam int NUM_REGS = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_INNER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_OUTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OUTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_THRESH = 3'd4;
  localparam logic [15:0] RST_INNER = 16'd9830;
  localparam logic [15:0] RST_OUTER = 16'd29491;
  localparam logic [7:0] RST_THRESH = 8'd128;
  localparam int SQRT_STEPS = 16;
  localparam int CR_STEPS = 16;
  localparam int AX_STEPS = 32;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic        sample_valid;
    logic        clear_marks;
    logic [15:0] button_word;
    logic signed [15:0] left_raw_x;
    logic signed [15:0] left_raw_y;
    logic signed [15:0] right_raw_x;
    logic signed [15:0] right_raw_y;
    logic [7:0]  trigger_raw;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] held_mask;
    logic [15:0] pressed_mask;
    logic signed [15:0] left_out_x;
    logic signed [15:0] left_out_y;
    logic signed [15:0] right_out_x;
    logic signed [15:0] right_out_y;
    logic        trigger_pulled;
  } out_beat_t;

  typedef enum logic [5:0] {
    OP_IDLE  = 6'b000001,
    OP_LOAD  = 6'b000010,
    OP_SQRT  = 6'b000100,
    OP_CR    = 6'b001000,
    OP_AXIS  = 6'b010000,
    OP_STORE = 6'b100000
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       stick;
    logic       axis;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic step_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// File: src/gpc_if.sv
// Interfaces: valid/ready channels for polls and results.
`default_nettype none
interface gpc_in_if;
  logic valid;
  logic ready;
  gpc_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gpc_out_if;
  logic valid;
  logic ready;
  gpc_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/gpc_ctrl.sv
// Controller: sequences root, remap and axis divides for both sticks.
`default_nettype none
module gpc_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic out_free,
  input  wire gpc_pkg::dp_sts_t sts,
  output gpc_pkg::dp_cmd_t cmd,
  output logic busy
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_SQRT  = 6'b000100,
    S_CR    = 6'b001000,
    S_AXIS  = 6'b010000,
    S_STORE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic stick_r, stick_nxt, axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    stick_nxt = stick_r;
    axis_nxt = axis_r;
    cmd.op = gpc_pkg::OP_IDLE;
    cmd.stick = stick_r;
    cmd.axis = axis_r;
    cmd.emit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOAD;
          stick_nxt = 1'b0;
          axis_nxt = 1'b0;
        end
      end
      S_LOAD: begin
        cmd.op = gpc_pkg::OP_LOAD;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = gpc_pkg::OP_SQRT;
        if (sts.step_done) state_nxt = S_CR;
      end
      S_CR: begin
        cmd.op = gpc_pkg::OP_CR;
        if (sts.step_done) state_nxt = S_AXIS;
      end
      S_AXIS: begin
        cmd.op = gpc_pkg::OP_AXIS;
        if (sts.step_done) begin
          if (!axis_r) begin
            axis_nxt = 1'b1;
          end else if (!stick_r) begin
            axis_nxt = 1'b0;
            stick_nxt = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_STORE;
          end
        end
      end
      S_STORE: begin
        cmd.op = gpc_pkg::OP_STORE;
        if (out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stick_r <= 1'b0;
      axis_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stick_r <= stick_nxt;
      axis_r <= axis_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_LOAD)) else $error("start lost");
  a_emit_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r == S_STORE && out_free)) else $error("stray emit");
  a_store_right: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> (stick_r && axis_r)) else $error("early store");
`endif
endmodule
`default_nettype wire

// File: src/gpc_dp.sv
// Datapath: button masks, shared square root and restoring divider, result register.
`default_nettype none
module gpc_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire gpc_pkg::in_beat_t in_beat,
  input  wire gpc_pkg::dp_cmd_t cmd,
  input  wire logic [15:0] left_inner,
  input  wire logic [15:0] left_outer,
  input  wire logic [15:0] right_inner,
  input  wire logic [15:0] right_outer,
  input  wire logic [7:0] thresh,
  output gpc_pkg::dp_sts_t sts,
  output gpc_pkg::out_beat_t res_beat
);
  logic [15:0] held_r, held_nxt, press_r, press_nxt;
  gpc_pkg::in_beat_t beat_r;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] root_r, root_nxt;
  logic [16:0] cr_r, cr_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [gpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [15:0] lx_r, ly_r, rx_r, ry_r;
  logic signed [15:0] ax_res;
  logic ax_wr;
  logic trig_r;

  logic signed [15:0] cur_x, cur_y, cur_v;
  logic [15:0] inner, outer, mag_v;
  logic [31:0] sq_x, sq_y;
  logic [33:0] trial;
  logic [32:0] dsub;
  logic [15:0] rdiff;
  logic [15:0] wordm, press_c;

  assign cur_x = cmd.stick ? beat_r.right_raw_x : beat_r.left_raw_x;
  assign cur_y = cmd.stick ? beat_r.right_raw_y : beat_r.left_raw_y;
  assign cur_v = cmd.axis ? cur_y : cur_x;
  assign inner = cmd.stick ? right_inner : left_inner;
  assign outer = cmd.stick ? right_outer : left_outer;
  assign mag_v = cur_v[15] ? 16'(-cur_v) : 16'(cur_v);
  assign sq_x = 32'($signed(cur_x) * $signed(cur_x));
  assign sq_y = 32'($signed(cur_y) * $signed(cur_y));
  assign wordm = in_beat.button_word & gpc_pkg::BUTTON_USED_MASK;
  assign press_c = in_beat.clear_marks ? 16'd0 : press_r;

  always_comb begin
    held_nxt = held_r;
    press_nxt = press_r;
    if (start) begin
      press_nxt = press_c;
      if (in_beat.sample_valid) begin
        press_nxt = (press_c & ~wordm) | (wordm & ~held_r);
        held_nxt = wordm;
      end
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    root_nxt = root_r;
    cr_nxt = cr_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    ax_wr = 1'b0;
    ax_res = '0;
    trial = '0;
    dsub = '0;
    rdiff = '0;
    sts.step_done = 1'b0;
    unique case (cmd.op)
      gpc_pkg::OP_LOAD: begin
        num_nxt = sq_x + sq_y;
        rem_nxt = '0;
        root_nxt = '0;
        cnt_nxt = '0;
      end
      gpc_pkg::OP_SQRT: begin
        trial = {rem_r, num_r[31:30]} - {16'd0, root_r, 2'b01};
        if (!trial[33]) begin
          rem_nxt = trial[31:0];
          root_nxt = {root_r[14:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[29:0], num_r[31:30]};
          root_nxt = {root_r[14:0], 1'b0};
        end
        num_nxt = {num_r[29:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gpc_pkg::CNT_W'(gpc_pkg::SQRT_STEPS - 1)) begin
          sts.step_done = 1'b1;
          cnt_nxt = '0;
          rdiff = root_nxt - inner;
          rem_nxt = {18'd0, rdiff[15:2]};
          num_nxt = {rdiff[1:0], 30'd0};
          if (root_nxt <= inner) begin
            cr_nxt = '0;
            cnt_nxt = gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS + 1);
          end else if (root_nxt >= outer) begin
            cr_nxt = {1'b0, gpc_pkg::ONE_Q15};
            cnt_nxt = gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS + 1);
          end
        end
      end
      gpc_pkg::OP_CR: begin
        if (cnt_r > gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS)) begin
          sts.step_done = 1'b1;
          cnt_nxt = '0;
          rem_nxt = '0;
        end else begin
          dsub = {rem_r[31:0], num_r[31]} - {17'd0, 16'(outer - inner)};
          if (!dsub[32]) begin
            rem_nxt = dsub[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], num_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
          num_nxt = {num_r[30:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS * 2 - 1)) begin
            cnt_nxt = '0;
          end
          if (cnt_r == '0) quo_nxt = '0;
          if (cnt_r == gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS)) begin
            cr_nxt = (quo_nxt[16:0] > 17'(gpc_pkg::ONE_Q15)) ?
                     {1'b0, gpc_pkg::ONE_Q15} : quo_nxt[16:0];
            cnt_nxt = gpc_pkg::CNT_W'(gpc_pkg::CR_STEPS + 1);
          end
        end
      end
      gpc_pkg::OP_AXIS: begin
        if (cnt_r == '0) begin
          num_nxt = 32'(mag_v) * 32'(cr_r);
          quo_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = gpc_pkg::CNT_W'(1);
        end else begin
          dsub = {rem_r[31:0], num_r[31]} - {17'd0, root_r};
          if (!dsub[32]) begin
            rem_nxt = dsub[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], num_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
          num_nxt = {num_r[30:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == gpc_pkg::CNT_W'(gpc_pkg::AX_STEPS)) begin
            sts.step_done = 1'b1;
            ax_wr = 1'b1;
            cnt_nxt = '0;
            if (root_r != '0) begin
              if (cur_v[15]) begin
                ax_res = ({rem_r[30:0], num_r[31]} >= 32'(root_r)) ?
                         (({quo_r[30:0], 1'b1} > 32'd32768) ? -16'sd32768 :
                          -$signed(16'({quo_r[30:0], 1'b1}))) :
                         (({quo_r[30:0], 1'b0} > 32'd32768) ? -16'sd32768 :
                          -$signed(16'({quo_r[30:0], 1'b0})));
              end else begin
                ax_res = ({rem_r[30:0], num_r[31]} >= 32'(root_r)) ?
                         (({quo_r[30:0], 1'b1} > 32'd32767) ? 16'sd32767 :
                          $signed(16'({quo_r[30:0], 1'b1}))) :
                         (({quo_r[30:0], 1'b0} > 32'd32767) ? 16'sd32767 :
                          $signed(16'({quo_r[30:0], 1'b0})));
              end
            end
          end
        end
      end
      gpc_pkg::OP_IDLE, gpc_pkg::OP_STORE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      press_r <= '0;
      cnt_r <= '0;
    end else begin
      held_r <= held_nxt;
      press_r <= press_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      beat_r <= in_beat;
      trig_r <= (in_beat.trigger_raw >= thresh);
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    root_r <= root_nxt;
    cr_r <= cr_nxt;
    quo_r <= quo_nxt;
    if (ax_wr) begin
      unique case ({cmd.stick, cmd.axis})
        2'b00: lx_r <= ax_res;
        2'b01: ly_r <= ax_res;
        2'b10: rx_r <= ax_res;
        2'b11: ry_r <= ax_res;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_beat.held_mask = held_r;
    res_beat.pressed_mask = press_r;
    res_beat.left_out_x = lx_r;
    res_beat.left_out_y = ly_r;
    res_beat.right_out_x = rx_r;
    res_beat.right_out_y = ry_r;
    res_beat.trigger_pulled = trig_r;
  end

`ifndef SYNTHESIS
  a_bits_unused_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((held_r | press_r) & ~gpc_pkg::BUTTON_USED_MASK) == 16'd0) else $error("unused bit");
  a_masks_still: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(start) |-> ($stable(held_r) && $stable(press_r))) else $error("mask moved");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= gpc_pkg::CNT_W'(gpc_pkg::AX_STEPS)) else $error("count overrun");
`endif
endmodule
`default_nettype wire

// File: src/gamepad_poll_conditioner.sv
// Top level: configuration registers, controller, datapath and output register.
// Usage: one poll beat enters on the in_ channel when in_valid and in_ready are
// high at a clock edge; one result beat leaves on the out_ channel when
// out_valid and out_ready are high. Polls are taken one at a time.
// Timing from acceptance to out_valid is set by the shared bit-serial square
// root and restoring divider that serve both sticks and both axes in turn. A
// stick radius at or below the inner zone or at or above the outer zone skips
// the remap divide. A new poll is accepted the cycle after the previous result
// is handed to the output register. A stalled receiver holds at most one
// result while the next poll computes; the datapath then waits for the output
// register.
// cfg_we writes register cfg_index with cfg_data at a clock edge; write only
// while idle. Reset (rst_n low, synchronous) clears both button masks, loads
// the default dead zones and threshold, and empties the output register.
`default_nettype none
module gamepad_poll_conditioner (
  input  wire logic clk,
  input  wire logic rst_n,
  gpc_in_if.sink    in_ch,
  gpc_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic [15:0] li_r, lo_r, ri_r, ro_r;
  logic [7:0] th_r;
  logic busy, start, out_free;
  logic ov_r, ov_nxt;
  gpc_pkg::out_beat_t od_r, res_beat;
  gpc_pkg::dp_cmd_t cmd;
  gpc_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r <= gpc_pkg::RST_INNER;
      lo_r <= gpc_pkg::RST_OUTER;
      ri_r <= gpc_pkg::RST_INNER;
      ro_r <= gpc_pkg::RST_OUTER;
      th_r <= gpc_pkg::RST_THRESH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpc_pkg::REG_LEFT_INNER: li_r <= cfg_data;
        gpc_pkg::REG_LEFT_OUTER: lo_r <= cfg_data;
        gpc_pkg::REG_RIGHT_INNER: ri_r <= cfg_data;
        gpc_pkg::REG_RIGHT_OUTER: ro_r <= cfg_data;
        gpc_pkg::REG_TRIG_THRESH: th_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign start = in_ch.valid && !busy;
  assign out_free = !ov_r || out_ch.ready;

  gpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  gpc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .start(start), .in_beat(in_ch.data), .cmd(cmd),
    .left_inner(li_r), .left_outer(lo_r), .right_inner(ri_r), .right_outer(ro_r),
    .thresh(th_r), .sts(sts), .res_beat(res_beat)
  );

  always_comb begin
    ov_nxt = ov_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    if (cmd.emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= ov_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) od_r <= res_beat;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |-> !cmd.emit) else $error("result overwritten");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid) else $error("result not shown");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("stalled beat moved");
`endif
endmodule
`default_nettype wire
